// ----- rtl/kmst_pkg.sv -----
// Shared widths and constants for the Kruskal union-find MST unit.
package kmst_pkg;

    localparam int VERTEX_W = 10;
    localparam int COST_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int EPOCH_W  = 4;

    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 10'd1023;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 32'sh8000_0000;

    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

endpackage

// ----- rtl/kmst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- rtl/kruskal_union_find_mst_unit.sv -----
// Kruskal MST accumulator: takes one pre-sorted edge per request and returns one result per
// request. The union-find forest (union by size, no path compression) sits in one RAM with a
// registered read. Each request checks its endpoints, walks each endpoint up to its root one
// parent link at a time, then writes the summed size into the larger root (the from-side one
// on a tie) and links the other root under it when the edge is taken; a bad endpoint skips
// the walks. Forest entries carry a graph tag, so first_edge clears the forest at once; after
// reset and on every 16th first_edge a clearing pass rewrites the whole RAM and the block
// stalls requests meanwhile. Configuration writes are taken at any time.
module kruskal_union_find_mst_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [kmst_pkg::VERTEX_W-1:0]        i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_first_edge,
    input  logic                                 i_last_edge,
    input  logic [kmst_pkg::VERTEX_W-1:0]        i_from_vertex,
    input  logic [kmst_pkg::VERTEX_W-1:0]        i_to_vertex,
    input  logic signed [kmst_pkg::COST_W-1:0]   i_edge_cost,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_joined,
    output logic                                 o_bad_vertex,
    output logic signed [kmst_pkg::TOTAL_W-1:0]  o_running_total,
    output logic                                 o_final_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int EW = AW + 1;
    localparam int MW = kmst_pkg::EPOCH_W + EW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic signed [EW-1:0] SINGLETON = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_WALK_A,
        S_WALK_B,
        S_MERGE,
        S_LINK,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic                                  r_item;
    logic [AW-1:0]                         r_cnt;
    logic [kmst_pkg::EPOCH_W-1:0]          r_epoch;
    logic [kmst_pkg::VERTEX_W-1:0]         r_vcount;
    logic signed [kmst_pkg::TOTAL_W-1:0]   r_total;

    logic                                  r_last;
    logic [kmst_pkg::VERTEX_W-1:0]         r_from;
    logic [kmst_pkg::VERTEX_W-1:0]         r_to;
    logic signed [kmst_pkg::COST_W-1:0]    r_cost;
    logic [AW-1:0]                         r_cur;
    logic [AW-1:0]                         r_ra;
    logic [AW-1:0]                         r_rb;
    logic signed [EW-1:0]                  r_sa;
    logic signed [EW-1:0]                  r_sb;
    logic                                  r_joined;
    logic                                  r_bad;

    logic                                  ram_wr_en;
    logic [AW-1:0]                         ram_wr_addr;
    logic [MW-1:0]                         ram_wr_data;
    logic [AW-1:0]                         ram_rd_addr;
    logic [MW-1:0]                         ram_rd_data;

    logic signed [EW-1:0]                  entry_val;
    logic [AW-1:0]                         entry_parent;
    logic                                  entry_is_root;
    logic signed [EW-1:0]                  size_sum;
    logic                                  a_keeps;
    logic                                  out_free;
    logic                                  accept;
    logic                                  bad_now;
    logic signed [kmst_pkg::TOTAL_W:0]     wide_sum;
    logic signed [kmst_pkg::TOTAL_W-1:0]   sat_sum;

    function automatic logic vertex_ok(input logic [kmst_pkg::VERTEX_W-1:0] v,
                                       input logic [kmst_pkg::VERTEX_W-1:0] vc);
        return (v != '0) && (v <= vc) && (32'(v) < MAX_VERTICES);
    endfunction

    // entries tagged with an older graph read as singleton roots
    assign entry_val = (ram_rd_data[MW-1 -: kmst_pkg::EPOCH_W] == r_epoch)
                     ? $signed(ram_rd_data[EW-1:0]) : SINGLETON;
    assign entry_parent  = entry_val[AW-1:0];
    assign entry_is_root = entry_val[EW-1];

    assign size_sum = r_sa + r_sb;
    assign a_keeps  = (r_sa <= r_sb);
    assign bad_now  = !vertex_ok(r_from, r_vcount) || !vertex_ok(r_to, r_vcount);

    assign wide_sum = {r_total[kmst_pkg::TOTAL_W-1], r_total}
                    + (kmst_pkg::TOTAL_W+1)'(r_cost);
    always_comb begin
        if (wide_sum > (kmst_pkg::TOTAL_W+1)'(kmst_pkg::TOTAL_MAX)) begin
            sat_sum = kmst_pkg::TOTAL_MAX;
        end else if (wide_sum < (kmst_pkg::TOTAL_W+1)'(kmst_pkg::TOTAL_MIN)) begin
            sat_sum = kmst_pkg::TOTAL_MIN;
        end else begin
            sat_sum = wide_sum[kmst_pkg::TOTAL_W-1:0];
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    always_comb begin
        ram_rd_addr = r_cur;
        case (r_state)
            S_CHECK:  ram_rd_addr = AW'(r_from);
            S_WALK_A: ram_rd_addr = entry_is_root ? AW'(r_to) : entry_parent;
            S_WALK_B: ram_rd_addr = entry_is_root ? r_cur : entry_parent;
            default:  ram_rd_addr = r_cur;
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cnt;
        ram_wr_data = {r_epoch, SINGLETON};
        case (r_state)
            S_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            S_MERGE: begin
                ram_wr_en   = (r_ra != r_rb);
                ram_wr_addr = a_keeps ? r_ra : r_rb;
                ram_wr_data = {r_epoch, size_sum};
            end
            S_LINK: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = a_keeps ? r_rb : r_ra;
                ram_wr_data = {r_epoch, 1'b0, (a_keeps ? r_ra : r_rb)};
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    kmst_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_VERTICES)
    ) u_forest (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_item   <= 1'b0;
            r_cnt    <= '0;
            r_epoch  <= '0;
            r_vcount <= kmst_pkg::VCOUNT_RESET;
            r_total  <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last_edge;
                        r_from <= i_from_vertex;
                        r_to   <= i_to_vertex;
                        r_cost <= i_edge_cost;
                        r_item <= 1'b1;
                        if (i_first_edge) begin
                            r_total <= '0;
                        end
                        if (i_first_edge && r_epoch == kmst_pkg::EPOCH_LAST) begin
                            r_epoch <= '0;
                            r_cnt   <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_CHECK;
                            if (i_first_edge) begin
                                r_epoch <= r_epoch + 1'b1;
                            end
                        end
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ADDR) begin
                        r_state <= r_item ? S_CHECK : S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_joined <= 1'b0;
                    r_bad    <= bad_now;
                    r_cur    <= AW'(r_from);
                    r_state  <= bad_now ? S_DONE : S_WALK_A;
                end
                S_WALK_A: begin
                    if (entry_is_root) begin
                        r_ra    <= r_cur;
                        r_sa    <= entry_val;
                        r_cur   <= AW'(r_to);
                        r_state <= S_WALK_B;
                    end else begin
                        r_cur <= entry_parent;
                    end
                end
                S_WALK_B: begin
                    if (entry_is_root) begin
                        r_rb    <= r_cur;
                        r_sb    <= entry_val;
                        r_state <= S_MERGE;
                    end else begin
                        r_cur <= entry_parent;
                    end
                end
                S_MERGE: begin
                    if (r_ra != r_rb) begin
                        r_total  <= sat_sum;
                        r_joined <= 1'b1;
                        r_state  <= S_LINK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_LINK: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_joined        <= r_joined;
                        o_bad_vertex    <= r_bad;
                        o_running_total <= r_total;
                        o_final_res     <= r_last;
                        r_item          <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
